// ===== rtl/i2crb_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crb_pkg
// Shared constants, codes and types for the I2C register bank servo control.
// ----------------------------------------------------------------------------
package i2crb_pkg;

    // bank and receive buffer sizes
    localparam int BANK_SIZE = 10;
    localparam int MAX_BYTES = 10;

    localparam int BANK_AW = $clog2(BANK_SIZE);
    localparam int RX_AW   = $clog2(MAX_BYTES);
    localparam int RX_CW   = $clog2(MAX_BYTES + 1);

    // fixed register places
    localparam int TOGGLE_INDEX = 8;
    localparam int PG_INDEX     = 9;
    localparam int NUM_MIRROR   = 6;

    localparam logic [7:0] PULSE_HI_INIT = 8'h05;
    localparam logic [7:0] PULSE_LO_INIT = 8'hDC;

    // event codes from the bus front end
    typedef enum logic [2:0] {
        MODE_WR_START = 3'd0,
        MODE_BYTE     = 3'd1,
        MODE_RD_START = 3'd2,
        MODE_RD_NEXT  = 3'd3,
        MODE_NACK     = 3'd4,
        MODE_BUS_ERR  = 3'd5,
        MODE_PG       = 3'd6
    } t_mode;

    // commit outcome
    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_DONE   = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    // one result transaction
    typedef struct packed {
        logic [7:0]  read_byte;
        logic        read_valid;
        t_status     write_status;
        logic [15:0] servo1_pulse;
        logic [15:0] servo2_pulse;
        logic [15:0] servo3_pulse;
        logic [6:0]  toggle_pins;
    } t_result;

    // port requests toward the two memories
    typedef struct packed {
        logic               we;
        logic [BANK_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [BANK_AW-1:0] raddr;
    } t_bank_req;

    typedef struct packed {
        logic             we;
        logic [RX_AW-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [RX_AW-1:0] raddr;
    } t_rx_req;

    // reset content of the register bank
    function automatic logic [7:0] bank_init(input logic [7:0] addr);
        logic [7:0] v;
        v = 8'h00;
        if (addr < 8'd8) begin
            v = addr[0] ? PULSE_LO_INIT : PULSE_HI_INIT;
        end
        return v;
    endfunction

endpackage

// ===== rtl/i2crb_ram.sv =====
// ----------------------------------------------------------------------------
// i2crb_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module i2crb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/i2crb_core.sv =====
// ----------------------------------------------------------------------------
// i2crb_core
// Event sequencer: counters, entry valid bits, commit copy loop and the
// mirror of the servo and toggle registers.
// ----------------------------------------------------------------------------
module i2crb_core
    import i2crb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_rx_byte,
    input  logic [6:0] i_pg_pins,
    input  logic       i_slot_free,
    output logic       o_res_valid,
    output t_result    o_res,
    output t_bank_req  o_bank_req,
    input  logic [7:0] i_bank_rdata,
    output t_rx_req    o_rx_req,
    input  logic [7:0] i_rx_rdata
);

    localparam logic [8:0] BANK_LIM = 9'(BANK_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PTR,
        S_RD,
        S_CPTR,
        S_COPY,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [RX_CW-1:0]   r_rx_count, n_rx_count;
    logic [7:0]         r_tx, n_tx;
    logic [7:0]         r_rptr, n_rptr;
    logic [MAX_BYTES-1:0] r_v_rx, n_v_rx;
    logic [BANK_SIZE-1:0] r_v_bank, n_v_bank;
    logic [7:0]         r_mir [NUM_MIRROR];
    logic [7:0]         n_mir [NUM_MIRROR];
    logic [6:0]         r_tog, n_tog;
    logic [RX_CW-1:0]   r_n, n_n;
    logic [RX_CW-1:0]   r_k, n_k;
    logic [7:0]         r_waddr, n_waddr;
    logic [BANK_AW-1:0] r_raddr, n_raddr;
    logic               r_rd_in, n_rd_in;
    logic [7:0]         r_rbyte, n_rbyte;
    logic               r_rvalid, n_rvalid;
    t_status            r_status, n_status;

    logic [7:0] tx_inc;
    logic [8:0] rd_addr;
    logic [7:0] ptr_val;
    logic [7:0] bank_val;
    logic [7:0] copy_data;

    // masked views of memory read data
    assign ptr_val   = r_v_rx[0] ? i_rx_rdata : 8'h00;
    assign bank_val  = r_v_bank[r_raddr] ? i_bank_rdata : bank_init(8'(r_raddr));
    assign copy_data = r_v_rx[r_k[RX_AW-1:0]] ? i_rx_rdata : 8'h00;
    assign tx_inc    = (r_tx != 8'hFF) ? r_tx + 8'd1 : r_tx;

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_rx_count = r_rx_count;
        n_tx       = r_tx;
        n_rptr     = r_rptr;
        n_v_rx     = r_v_rx;
        n_v_bank   = r_v_bank;
        n_mir      = r_mir;
        n_tog      = r_tog;
        n_n        = r_n;
        n_k        = r_k;
        n_waddr    = r_waddr;
        n_raddr    = r_raddr;
        n_rd_in    = r_rd_in;
        n_rbyte    = r_rbyte;
        n_rvalid   = r_rvalid;
        n_status   = r_status;
        o_bank_req = '0;
        o_rx_req   = '0;
        rd_addr    = 9'd0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rbyte  = 8'h00;
                    n_rvalid = 1'b0;
                    n_status = ST_NONE;
                    n_state  = S_DONE;
                    case (t_mode'(i_mode))
                        MODE_WR_START: begin
                            n_v_rx[0]  = 1'b0;
                            n_rx_count = '0;
                            n_tx       = 8'h00;
                        end
                        MODE_BYTE: begin
                            if (r_rx_count < RX_CW'(MAX_BYTES)) begin
                                o_rx_req.we    = 1'b1;
                                o_rx_req.waddr = r_rx_count[RX_AW-1:0];
                                o_rx_req.wdata = i_rx_byte;
                                n_v_rx[r_rx_count[RX_AW-1:0]] = 1'b1;
                                n_rx_count = r_rx_count + RX_CW'(1);
                                // buffer fills: commit
                                if (r_rx_count == RX_CW'(MAX_BYTES - 1)) begin
                                    n_n            = RX_CW'(MAX_BYTES - 1);
                                    o_rx_req.re    = 1'b1;
                                    o_rx_req.raddr = '0;
                                    n_state        = S_CPTR;
                                end
                            end
                        end
                        MODE_RD_START: begin
                            n_tx           = 8'h00;
                            o_rx_req.re    = 1'b1;
                            o_rx_req.raddr = '0;
                            n_state        = S_PTR;
                        end
                        MODE_RD_NEXT: begin
                            n_tx              = tx_inc;
                            rd_addr           = {1'b0, r_rptr} + {1'b0, tx_inc};
                            n_rd_in           = rd_addr < BANK_LIM;
                            n_raddr           = rd_addr[BANK_AW-1:0];
                            o_bank_req.re     = n_rd_in;
                            o_bank_req.raddr  = rd_addr[BANK_AW-1:0];
                            n_state           = S_RD;
                        end
                        MODE_NACK: begin
                            if (r_tx == 8'h00) begin
                                n_rx_count = '0;
                                if (r_rx_count != '0) begin
                                    n_n            = r_rx_count - RX_CW'(1);
                                    o_rx_req.re    = 1'b1;
                                    o_rx_req.raddr = '0;
                                    n_state        = S_CPTR;
                                end
                            end else begin
                                n_tx = 8'h00;
                            end
                        end
                        MODE_BUS_ERR: begin
                            n_v_rx     = '0;
                            n_rx_count = '0;
                            n_tx       = 8'h00;
                        end
                        MODE_PG: begin
                            o_bank_req.we    = 1'b1;
                            o_bank_req.waddr = BANK_AW'(PG_INDEX);
                            o_bank_req.wdata = {1'b0, i_pg_pins};
                            n_v_bank[PG_INDEX] = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // read start: pointer arrives, then fetch the bank byte
            S_PTR: begin
                n_rptr           = ptr_val;
                n_v_rx[0]        = 1'b0;
                rd_addr          = {1'b0, ptr_val};
                n_rd_in          = rd_addr < BANK_LIM;
                n_raddr          = rd_addr[BANK_AW-1:0];
                o_bank_req.re    = n_rd_in;
                o_bank_req.raddr = rd_addr[BANK_AW-1:0];
                n_state          = S_RD;
            end

            S_RD: begin
                n_rbyte  = r_rd_in ? bank_val : 8'h00;
                n_rvalid = 1'b1;
                n_state  = S_DONE;
            end

            // commit: range check on pointer plus byte count
            S_CPTR: begin
                if ({1'b0, ptr_val} + 9'(r_n) > BANK_LIM) begin
                    n_status = ST_REJECT;
                    n_state  = S_DONE;
                end else if (r_n == '0) begin
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                end else begin
                    n_waddr        = ptr_val;
                    n_k            = RX_CW'(1);
                    o_rx_req.re    = 1'b1;
                    o_rx_req.raddr = RX_AW'(1);
                    n_state        = S_COPY;
                end
            end

            // commit: one buffered byte into the bank per cycle
            S_COPY: begin
                o_bank_req.we    = 1'b1;
                o_bank_req.waddr = r_waddr[BANK_AW-1:0];
                o_bank_req.wdata = copy_data;
                n_v_bank[r_waddr[BANK_AW-1:0]] = 1'b1;
                for (int i = 0; i < NUM_MIRROR; i++) begin
                    if (r_waddr == 8'(i)) begin
                        n_mir[i] = copy_data;
                    end
                end
                if (r_waddr == 8'(TOGGLE_INDEX)) begin
                    n_tog = copy_data[6:0];
                end
                n_waddr = r_waddr + 8'd1;
                if (r_k == r_n) begin
                    n_status = ST_DONE;
                    n_state  = S_DONE;
                end else begin
                    n_k            = r_k + RX_CW'(1);
                    o_rx_req.re    = 1'b1;
                    o_rx_req.raddr = r_k[RX_AW-1:0] + RX_AW'(1);
                end
            end

            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rx_count <= '0;
            r_tx       <= 8'h00;
            r_rptr     <= 8'h00;
            r_v_rx     <= '0;
            r_v_bank   <= '0;
            for (int i = 0; i < NUM_MIRROR; i++) begin
                r_mir[i] <= bank_init(8'(i));
            end
            r_tog      <= 7'(bank_init(8'(TOGGLE_INDEX)));
        end else begin
            r_state    <= n_state;
            r_rx_count <= n_rx_count;
            r_tx       <= n_tx;
            r_rptr     <= n_rptr;
            r_v_rx     <= n_v_rx;
            r_v_bank   <= n_v_bank;
            r_mir      <= n_mir;
            r_tog      <= n_tog;
        end
        r_n      <= n_n;
        r_k      <= n_k;
        r_waddr  <= n_waddr;
        r_raddr  <= n_raddr;
        r_rd_in  <= n_rd_in;
        r_rbyte  <= n_rbyte;
        r_rvalid <= n_rvalid;
        r_status <= n_status;
    end

    // handshake and result assembly
    assign o_in_stall              = (r_state != S_IDLE);
    assign o_res_valid             = (r_state == S_DONE);
    assign o_res.read_byte         = r_rbyte;
    assign o_res.read_valid        = r_rvalid;
    assign o_res.write_status      = r_status;
    assign o_res.servo1_pulse      = {r_mir[0], r_mir[1]};
    assign o_res.servo2_pulse      = {r_mir[2], r_mir[3]};
    assign o_res.servo3_pulse      = {r_mir[4], r_mir[5]};
    assign o_res.toggle_pins       = r_tog;

endmodule

// ===== rtl/i2c_register_bank_servo_ctrl_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_register_bank_servo_ctrl_unit
// Byte-level I2C target register bank driving servo compare values.
// ----------------------------------------------------------------------------
// Usage: the bus front end sends one transaction per bus event (mode,
// received byte, power-good pins) on the input channel; each yields exactly
// one result transaction with the read byte, commit status and the current
// servo compare values and toggle pins.
// Both channels use valid/stall; a transaction moves when valid is high
// and stall is low. One event is processed at a time.
// A commit of n data bytes (up to 9 with the default buffer) runs a copy
// loop that moves one byte per cycle from the receive buffer memory into
// the bank memory.
// The core returns to idle as the result enters the output register, so
// the next event can be taken even while that result still waits.
// Reset (synchronous, active low) restores the bank to its power-on content
// and empties the receive buffer through per-entry valid bits, with no
// clearing pass. A stalled receiver holds the output register; once the
// register is full and the core has a further result, the input stalls.
// ----------------------------------------------------------------------------
module i2c_register_bank_servo_ctrl_unit
    import i2crb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_rx_byte,
    input  logic [6:0]  i_pg_pins,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_byte,
    output logic        o_read_valid,
    output logic [1:0]  o_write_status,
    output logic [15:0] o_servo1_pulse,
    output logic [15:0] o_servo2_pulse,
    output logic [15:0] o_servo3_pulse,
    output logic [6:0]  o_toggle_pins
);

    t_bank_req  bank_req;
    t_rx_req    rx_req;
    logic [7:0] bank_rdata;
    logic [7:0] rx_rdata;
    logic       res_valid;
    t_result    res;
    logic       slot_free;

    logic       r_out_valid;
    t_result    r_out;

    assign slot_free = !r_out_valid || !i_out_stall;

    i2crb_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_rx_byte    (i_rx_byte),
        .i_pg_pins    (i_pg_pins),
        .i_slot_free  (slot_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_bank_req   (bank_req),
        .i_bank_rdata (bank_rdata),
        .o_rx_req     (rx_req),
        .i_rx_rdata   (rx_rdata)
    );

    // register bank memory
    i2crb_ram #(
        .WIDTH (8),
        .DEPTH (BANK_SIZE)
    ) u_bank_ram (
        .i_clk   (i_clk),
        .i_we    (bank_req.we),
        .i_waddr (bank_req.waddr),
        .i_wdata (bank_req.wdata),
        .i_re    (bank_req.re),
        .i_raddr (bank_req.raddr),
        .o_rdata (bank_rdata)
    );

    // receive buffer memory
    i2crb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_req.we),
        .i_waddr (rx_req.waddr),
        .i_wdata (rx_req.wdata),
        .i_re    (rx_req.re),
        .i_raddr (rx_req.raddr),
        .o_rdata (rx_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
        if (slot_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_byte    = r_out.read_byte;
    assign o_read_valid   = r_out.read_valid;
    assign o_write_status = r_out.write_status;
    assign o_servo1_pulse = r_out.servo1_pulse;
    assign o_servo2_pulse = r_out.servo2_pulse;
    assign o_servo3_pulse = r_out.servo3_pulse;
    assign o_toggle_pins  = r_out.toggle_pins;

endmodule

// ===== rtl/i2crb_checker.sv =====
// ----------------------------------------------------------------------------
// i2crb_checker
// Port-level checks for the register bank unit, bound to the top level.
// ----------------------------------------------------------------------------
module i2crb_checker
    import i2crb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [2:0]  i_mode,
    input logic [7:0]  i_rx_byte,
    input logic [6:0]  i_pg_pins,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_read_byte,
    input logic        o_read_valid,
    input logic [1:0]  o_write_status,
    input logic [15:0] o_servo1_pulse,
    input logic [15:0] o_servo2_pulse,
    input logic [15:0] o_servo3_pulse,
    input logic [6:0]  o_toggle_pins
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // one event in flight: accepted transaction blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on two consecutive cycles");

    // a read result never reports a commit
    a_read_no_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_read_valid) |-> (o_write_status == ST_NONE))
        else $error("read result carries commit status");

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_mode)
            && $stable(i_rx_byte) && $stable(i_pg_pins)))
        else $error("stalled input changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_servo1_pulse)
            && $stable(o_servo2_pulse) && $stable(o_servo3_pulse)
            && $stable(o_toggle_pins) && $stable(o_read_valid)
            && $stable(o_read_byte) && $stable(o_write_status)))
        else $error("stalled result changed");

endmodule

bind i2c_register_bank_servo_ctrl_unit i2crb_checker u_i2crb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_mode         (i_mode),
    .i_rx_byte      (i_rx_byte),
    .i_pg_pins      (i_pg_pins),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_read_byte    (o_read_byte),
    .o_read_valid   (o_read_valid),
    .o_write_status (o_write_status),
    .o_servo1_pulse (o_servo1_pulse),
    .o_servo2_pulse (o_servo2_pulse),
    .o_servo3_pulse (o_servo3_pulse),
    .o_toggle_pins  (o_toggle_pins)
);

// ===== tb/sv/i2c_register_bank_servo_ctrl_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_register_bank_servo_ctrl_unit_tb
// Drives bus events into the register bank and checks every result
// transaction against an in-bench model of the bank, receive buffer and read
// counters. A directed part covers reset content, buffer fill, rejected and
// empty commits, reads past the bank, bus error and power-good sampling; random
// write and read transactions then run under several idle and stall patterns.
// ----------------------------------------------------------------------------
module i2c_register_bank_servo_ctrl_unit_tb;
    import i2crb_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  mode = MODE_WR_START;
    logic [7:0]  rx_byte = 8'h00;
    logic [6:0]  pg_pins = 7'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic [1:0]  write_status;
    logic [15:0] servo1_pulse;
    logic [15:0] servo2_pulse;
    logic [15:0] servo3_pulse;
    logic [6:0]  toggle_pins;

    // bank, receive buffer and counters as the block should hold them
    logic [7:0] bank_img [BANK_SIZE];
    logic [7:0] rxbuf_img [MAX_BYTES];
    int         rx_fill;
    int         tx_idx;
    int         rd_base;

    t_result bus_results_q [$];
    int      mismatches = 0;
    int      events_sent = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;

    i2c_register_bank_servo_ctrl_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_mode         (mode),
        .i_rx_byte      (rx_byte),
        .i_pg_pins      (pg_pins),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_read_byte    (read_byte),
        .o_read_valid   (read_valid),
        .o_write_status (write_status),
        .o_servo1_pulse (servo1_pulse),
        .o_servo2_pulse (servo2_pulse),
        .o_servo3_pulse (servo3_pulse),
        .o_toggle_pins  (toggle_pins)
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // hard stop
    initial begin
        #5_000_000;
        $display("i2c_register_bank_servo_ctrl_unit_tb failed");
        $finish;
    end

    // bank read, zero past the end
    function automatic logic [7:0] bank_peek(input int addr);
        if (addr < BANK_SIZE) begin
            return bank_img[addr];
        end
        return 8'h00;
    endfunction

    // copy the receive buffer into the bank, all or nothing
    function automatic t_status commit_rx();
        int ptr;
        int n;
        if (rx_fill == 0) begin
            return ST_NONE;
        end
        ptr = rxbuf_img[0];
        n = rx_fill - 1;
        if (ptr + n > BANK_SIZE) begin
            return ST_REJECT;
        end
        for (int k = 0; k < n; k++) begin
            bank_img[ptr + k] = rxbuf_img[k + 1];
        end
        return ST_DONE;
    endfunction

    // advance the bank image by one bus event and form its result
    function automatic t_result apply_bus_event(input t_mode m, input logic [7:0] b,
                                                input logic [6:0] pg);
        t_result r;
        r = '0;
        r.write_status = ST_NONE;
        case (m)
            MODE_WR_START: begin
                rxbuf_img[0] = 8'h00;
                rx_fill = 0;
                tx_idx = 0;
            end
            MODE_BYTE: begin
                if (rx_fill < MAX_BYTES) begin
                    rxbuf_img[rx_fill] = b;
                    rx_fill++;
                    if (rx_fill == MAX_BYTES) begin
                        r.write_status = commit_rx();
                    end
                end
            end
            MODE_RD_START: begin
                tx_idx = 0;
                rd_base = rxbuf_img[0];
                rxbuf_img[0] = 8'h00;
                r.read_byte = bank_peek(rd_base);
                r.read_valid = 1'b1;
            end
            MODE_RD_NEXT: begin
                if (tx_idx < 255) begin
                    tx_idx++;
                end
                r.read_byte = bank_peek(rd_base + tx_idx);
                r.read_valid = 1'b1;
            end
            MODE_NACK: begin
                if (tx_idx == 0) begin
                    r.write_status = commit_rx();
                    rx_fill = 0;
                end else begin
                    tx_idx = 0;
                end
            end
            MODE_BUS_ERR: begin
                for (int k = 0; k < MAX_BYTES; k++) begin
                    rxbuf_img[k] = 8'h00;
                end
                rx_fill = 0;
                tx_idx = 0;
            end
            MODE_PG: begin
                bank_img[PG_INDEX] = {1'b0, pg};
            end
            default: begin
            end
        endcase
        r.servo1_pulse = {bank_peek(0), bank_peek(1)};
        r.servo2_pulse = {bank_peek(2), bank_peek(3)};
        r.servo3_pulse = {bank_peek(4), bank_peek(5)};
        r.toggle_pins = 7'(bank_peek(TOGGLE_INDEX));
        return r;
    endfunction

    // send one bus event, with random idle cycles ahead of it
    task automatic send_event(input t_mode m, input logic [7:0] b, input logic [6:0] pg);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        rx_byte  <= b;
        pg_pins  <= pg;
        bus_results_q.push_back(apply_bus_event(m, b, pg));
        events_sent++;
        do @(posedge clk); while (in_stall);
    endtask

    // receiver stall pattern
    always @(posedge clk) begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // compare each result transaction with the oldest expected one
    always @(posedge clk) begin : check_results
        t_result exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (bus_results_q.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatches++;
            end else begin
                exp_r = bus_results_q.pop_front();
                if (read_byte !== exp_r.read_byte) begin
                    $error("read_byte: expected %02h, got %02h", exp_r.read_byte, read_byte);
                    mismatches++;
                end
                if (read_valid !== exp_r.read_valid) begin
                    $error("read_valid: expected %0b, got %0b", exp_r.read_valid, read_valid);
                    mismatches++;
                end
                if (write_status !== exp_r.write_status) begin
                    $error("write_status: expected %0d, got %0d",
                           exp_r.write_status, write_status);
                    mismatches++;
                end
                if (servo1_pulse !== exp_r.servo1_pulse) begin
                    $error("servo1_pulse: expected %04h, got %04h",
                           exp_r.servo1_pulse, servo1_pulse);
                    mismatches++;
                end
                if (servo2_pulse !== exp_r.servo2_pulse) begin
                    $error("servo2_pulse: expected %04h, got %04h",
                           exp_r.servo2_pulse, servo2_pulse);
                    mismatches++;
                end
                if (servo3_pulse !== exp_r.servo3_pulse) begin
                    $error("servo3_pulse: expected %04h, got %04h",
                           exp_r.servo3_pulse, servo3_pulse);
                    mismatches++;
                end
                if (toggle_pins !== exp_r.toggle_pins) begin
                    $error("toggle_pins: expected %02h, got %02h",
                           exp_r.toggle_pins, toggle_pins);
                    mismatches++;
                end
            end
        end
    end

    // reads straight after reset see the power-on bank
    task automatic test_reset_readback();
        send_event(MODE_RD_START, 8'h00, 7'h00);
        send_event(MODE_RD_NEXT, 8'h00, 7'h00);
        send_event(MODE_NACK, 8'h00, 7'h00);
    endtask

    // filling the buffer commits, the extra byte is dropped, nack commits again
    task automatic test_full_buffer();
        send_event(MODE_WR_START, 8'h00, 7'h00);
        send_event(MODE_BYTE, 8'h01, 7'h00);
        for (int i = 1; i < MAX_BYTES; i++) begin
            send_event(MODE_BYTE, (i % 2 == 0) ? 8'hFF : 8'h00, 7'h00);
        end
        send_event(MODE_BYTE, 8'hA5, 7'h7F);
        send_event(MODE_NACK, 8'h00, 7'h00);
    endtask

    // update running past the bank end is rejected
    task automatic test_reject();
        send_event(MODE_WR_START, 8'h00, 7'h00);
        send_event(MODE_BYTE, 8'hFF, 7'h00);
        send_event(MODE_BYTE, 8'h55, 7'h00);
        send_event(MODE_NACK, 8'h00, 7'h00);
    endtask

    // read that crosses the bank end, then a bus error and an empty nack
    task automatic test_read_past_end();
        send_event(MODE_WR_START, 8'h00, 7'h00);
        send_event(MODE_BYTE, 8'h09, 7'h00);
        send_event(MODE_RD_START, 8'h00, 7'h00);
        send_event(MODE_RD_NEXT, 8'h00, 7'h00);
        send_event(MODE_NACK, 8'h00, 7'h00);
        send_event(MODE_BUS_ERR, 8'h00, 7'h00);
        send_event(MODE_NACK, 8'h00, 7'h00);
    endtask

    // power-good pins into the last register
    task automatic test_pg_sample();
        send_event(MODE_PG, 8'h00, 7'h7F);
        send_event(MODE_PG, 8'hFF, 7'h00);
    endtask

    // read long enough to saturate the byte counter
    task automatic test_long_read();
        send_event(MODE_WR_START, 8'h00, 7'h00);
        send_event(MODE_BYTE, 8'h03, 7'h00);
        send_event(MODE_RD_START, 8'h00, 7'h00);
        for (int i = 0; i < 258; i++) begin
            send_event(MODE_RD_NEXT, 8'($urandom_range(255)), 7'($urandom_range(127)));
        end
        send_event(MODE_NACK, 8'h00, 7'h00);
    endtask

    // random bus transactions, mostly well formed
    task automatic test_random_traffic(input int n_events, input int idle, input int stall);
        int stop_at;
        int sel;
        int ndata;
        int nread;
        logic [7:0] ptr;
        idle_pct = idle;
        stall_pct = stall;
        stop_at = events_sent + n_events;
        while (events_sent < stop_at) begin
            sel = $urandom_range(99);
            ptr = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(10));
            if (sel < 45) begin
                // write transaction
                send_event(MODE_WR_START, 8'($urandom_range(255)), 7'($urandom_range(127)));
                send_event(MODE_BYTE, ptr, 7'($urandom_range(127)));
                ndata = $urandom_range(MAX_BYTES);
                for (int i = 0; i < ndata; i++) begin
                    send_event(MODE_BYTE, 8'($urandom_range(255)), 7'($urandom_range(127)));
                end
                send_event(($urandom_range(9) == 0) ? MODE_BUS_ERR : MODE_NACK,
                           8'($urandom_range(255)), 7'($urandom_range(127)));
            end else if (sel < 75) begin
                // read transaction, usually with a pointer write first
                if ($urandom_range(9) < 7) begin
                    send_event(MODE_WR_START, 8'($urandom_range(255)),
                               7'($urandom_range(127)));
                    send_event(MODE_BYTE, ptr, 7'($urandom_range(127)));
                end
                send_event(MODE_RD_START, 8'($urandom_range(255)), 7'($urandom_range(127)));
                nread = $urandom_range(12);
                for (int i = 0; i < nread; i++) begin
                    send_event(MODE_RD_NEXT, 8'($urandom_range(255)),
                               7'($urandom_range(127)));
                end
                send_event(MODE_NACK, 8'($urandom_range(255)), 7'($urandom_range(127)));
            end else if (sel < 85) begin
                send_event(MODE_PG, 8'($urandom_range(255)), 7'($urandom_range(127)));
            end else begin
                // stray event
                send_event(t_mode'($urandom_range(6)), 8'($urandom_range(255)),
                           7'($urandom_range(127)));
            end
        end
    endtask

    // main sequence
    initial begin
        bank_img[0] = PULSE_HI_INIT;
        for (int k = 0; k < BANK_SIZE; k++) begin
            bank_img[k] = (k >= 8) ? 8'h00 : (k % 2 == 1) ? PULSE_LO_INIT : PULSE_HI_INIT;
        end
        for (int k = 0; k < MAX_BYTES; k++) begin
            rxbuf_img[k] = 8'h00;
        end
        rx_fill = 0;
        tx_idx = 0;
        rd_base = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_readback();
        test_full_buffer();
        test_reject();
        test_read_past_end();
        test_pg_sample();
        test_long_read();
        test_random_traffic(220, 0, 0);
        test_random_traffic(220, 83, 0);
        test_random_traffic(220, 0, 83);
        test_random_traffic(220, 33, 33);

        in_valid <= 1'b0;
        while (bus_results_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (mismatches == 0) begin
            $display("i2c_register_bank_servo_ctrl_unit_tb passed");
        end else begin
            $display("i2c_register_bank_servo_ctrl_unit_tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/i2crb_pkg.sv
rtl/i2crb_ram.sv
rtl/i2crb_core.sv
rtl/i2c_register_bank_servo_ctrl_unit.sv
rtl/i2crb_checker.sv
tb/sv/i2c_register_bank_servo_ctrl_unit_tb.sv
